>>> hdl/bc_pkg.sv
package bc_pkg;

  // geometry of one query
  localparam int unsigned NumPoints = 4;
  localparam int unsigned NumAxes   = 3;
  localparam int unsigned NumEdges  = 3;

  // dot product slots
  localparam int unsigned NumDots = 5;
  localparam int unsigned D00     = 0;
  localparam int unsigned D01     = 1;
  localparam int unsigned D11     = 2;
  localparam int unsigned D20     = 3;
  localparam int unsigned D21     = 4;

  // second level products: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20
  localparam int unsigned NumProds = 6;

  // quotient lanes
  localparam int unsigned NumLanes = 2;
  localparam int unsigned LaneV    = 0;
  localparam int unsigned LaneW    = 1;

  // result format
  localparam int unsigned WeightBits = 32;
  localparam logic [WeightBits-1:0] WeightMaxBits = {1'b0, {(WeightBits-1){1'b1}}};
  localparam logic [WeightBits-1:0] WeightMinBits = {1'b1, {(WeightBits-1){1'b0}}};

  // per item flags that travel alongside the quotient datapath
  typedef struct packed {
    logic                degen;
    logic [NumLanes-1:0] neg;
    logic [NumLanes-1:0] ovf;
  } bc_side_t;

endpackage

>>> hdl/bc_dot.sv
module bc_dot
  import bc_pkg::*;
#(
  parameter  int unsigned COORD_BITS = 16,
  localparam int unsigned EdgeBits   = COORD_BITS + 1,
  localparam int unsigned ProdBits   = 2 * EdgeBits,
  localparam int unsigned DotBits    = ProdBits + 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [COORD_BITS-1:0] pt_i [NumPoints][NumAxes],
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [DotBits-1:0]   dot_o [NumDots]
);

  localparam int unsigned NumStages = 3;
  // edge pairs per dot product: e0.e0, e0.e1, e1.e1, e2.e0, e2.e1
  localparam int unsigned DotEdgeA [NumDots] = '{0, 0, 1, 2, 2};
  localparam int unsigned DotEdgeB [NumDots] = '{0, 1, 1, 0, 1};

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  logic signed [EdgeBits-1:0] edge_d [NumEdges][NumAxes];
  logic signed [EdgeBits-1:0] edge_q [NumEdges][NumAxes];
  logic signed [ProdBits-1:0] prod_d [NumDots][NumAxes];
  logic signed [ProdBits-1:0] prod_q [NumDots][NumAxes];
  logic signed [DotBits-1:0]  dot_d  [NumDots];
  logic signed [DotBits-1:0]  dot_q  [NumDots];

  // stage enables, a stage moves when empty or when the next one moves
  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int s = 1; s < NumStages; s++) begin
        if (en[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // edge vectors relative to corner a
  always_comb begin
    for (int i = 0; i < NumEdges; i++) begin
      for (int k = 0; k < NumAxes; k++) begin
        edge_d[i][k] = EdgeBits'(pt_i[i+1][k]) - EdgeBits'(pt_i[0][k]);
      end
    end
  end

  // per axis products
  always_comb begin
    for (int j = 0; j < NumDots; j++) begin
      for (int k = 0; k < NumAxes; k++) begin
        prod_d[j][k] = edge_q[DotEdgeA[j]][k] * edge_q[DotEdgeB[j]][k];
      end
    end
  end

  // sum over axes
  always_comb begin
    for (int j = 0; j < NumDots; j++) begin
      dot_d[j] = DotBits'(prod_q[j][0]) + DotBits'(prod_q[j][1]) + DotBits'(prod_q[j][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) edge_q <= edge_d;
    if (en[1]) prod_q <= prod_d;
    if (en[2]) dot_q  <= dot_d;
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign dot_o       = dot_q;

endmodule

>>> hdl/bc_cross.sv
module bc_cross
  import bc_pkg::*;
#(
  parameter  int unsigned COORD_BITS = 16,
  localparam int unsigned EdgeBits   = COORD_BITS + 1,
  localparam int unsigned DotBits    = 2 * EdgeBits + 2,
  localparam int unsigned NumBits    = 2 * DotBits + 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [DotBits-1:0] dot_i [NumDots],
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [NumBits-1:0]        num_abs_o [NumLanes],
  output logic [NumBits-1:0]        den_abs_o,
  output bc_side_t                  side_o
);

  localparam int unsigned NumStages = 4;
  localparam int unsigned LoBits    = DotBits / 2;
  localparam int unsigned HiBits    = DotBits - LoBits;
  localparam int unsigned PlBits    = DotBits + LoBits + 1;
  localparam int unsigned PhBits    = DotBits + HiBits;
  localparam int unsigned FullBits  = 2 * DotBits;
  localparam int unsigned ProdA [NumProds] = '{D00, D01, D11, D01, D00, D01};
  localparam int unsigned ProdB [NumProds] = '{D11, D01, D20, D21, D21, D20};

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  logic signed [PlBits-1:0]   pl_d   [NumProds];
  logic signed [PlBits-1:0]   pl_q   [NumProds];
  logic signed [PhBits-1:0]   ph_d   [NumProds];
  logic signed [PhBits-1:0]   ph_q   [NumProds];
  logic signed [FullBits-1:0] full_d [NumProds];
  logic signed [FullBits-1:0] full_q [NumProds];
  logic signed [NumBits-1:0]  den_d, den_q;
  logic signed [NumBits-1:0]  num_d  [NumLanes];
  logic signed [NumBits-1:0]  num_q  [NumLanes];
  logic [NumBits-1:0]         den_abs_d, den_abs_q;
  logic [NumBits-1:0]         num_abs_d [NumLanes];
  logic [NumBits-1:0]         num_abs_q [NumLanes];
  bc_side_t                   side_d, side_q;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int s = 1; s < NumStages; s++) begin
        if (en[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // partial products, second operand split into a low unsigned and a high signed half
  always_comb begin
    for (int p = 0; p < NumProds; p++) begin
      pl_d[p] = dot_i[ProdA[p]] * $signed({1'b0, dot_i[ProdB[p]][LoBits-1:0]});
      ph_d[p] = dot_i[ProdA[p]] * $signed(dot_i[ProdB[p]][DotBits-1:LoBits]);
    end
  end

  // recombine the halves
  always_comb begin
    for (int p = 0; p < NumProds; p++) begin
      full_d[p] = (FullBits'(ph_q[p]) <<< LoBits) + FullBits'(pl_q[p]);
    end
  end

  // denominator and the two numerators
  always_comb begin
    den_d        = NumBits'(full_q[0]) - NumBits'(full_q[1]);
    num_d[LaneV] = NumBits'(full_q[2]) - NumBits'(full_q[3]);
    num_d[LaneW] = NumBits'(full_q[4]) - NumBits'(full_q[5]);
  end

  // magnitudes, quotient signs and the degenerate check
  always_comb begin
    den_abs_d    = den_q[NumBits-1] ? NumBits'(-den_q) : NumBits'(den_q);
    side_d.degen = (den_q == '0);
    side_d.ovf   = '0;
    for (int l = 0; l < NumLanes; l++) begin
      num_abs_d[l]  = num_q[l][NumBits-1] ? NumBits'(-num_q[l]) : NumBits'(num_q[l]);
      side_d.neg[l] = num_q[l][NumBits-1] ^ den_q[NumBits-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      pl_q <= pl_d;
      ph_q <= ph_d;
    end
    if (en[1]) full_q <= full_d;
    if (en[2]) begin
      den_q <= den_d;
      num_q <= num_d;
    end
    if (en[3]) begin
      den_abs_q <= den_abs_d;
      num_abs_q <= num_abs_d;
      side_q    <= side_d;
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign num_abs_o   = num_abs_q;
  assign den_abs_o   = den_abs_q;
  assign side_o      = side_q;

endmodule

>>> hdl/bc_div.sv
module bc_div
  import bc_pkg::*;
#(
  parameter  int unsigned COORD_BITS       = 16,
  parameter  int unsigned WEIGHT_FRAC_BITS = 16,
  localparam int unsigned EdgeBits         = COORD_BITS + 1,
  localparam int unsigned DotBits          = 2 * EdgeBits + 2,
  localparam int unsigned NumBits          = 2 * DotBits + 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [NumBits-1:0]    num_abs_i [NumLanes],
  input  logic [NumBits-1:0]    den_abs_i,
  input  bc_side_t              side_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WeightBits-1:0] quo_o [NumLanes],
  output bc_side_t              side_o
);

  localparam int unsigned DivBits       = NumBits + WEIGHT_FRAC_BITS;
  localparam int unsigned StepsPerStage = 2;
  localparam int unsigned NumSteps      = WeightBits / StepsPerStage;
  localparam int unsigned NumStages     = NumSteps + 1;
  localparam int unsigned StepBits      = NumBits + 2 * WeightBits;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  logic [NumBits-1:0]    den_q [NumStages];
  logic [NumBits-1:0]    rem_q [NumStages][NumLanes];
  logic [WeightBits-1:0] low_q [NumStages][NumLanes];
  logic [WeightBits-1:0] quo_q [NumStages][NumLanes];
  bc_side_t              side_q [NumStages];

  logic [DivBits-1:0]    dividend [NumLanes];
  logic [NumBits-1:0]    rem0_d   [NumLanes];
  logic [WeightBits-1:0] low0_d   [NumLanes];
  bc_side_t              side0_d;
  logic [StepBits-1:0]   step_d   [NumSteps][NumLanes];

  // restoring division steps, shifts in dividend bits from the top of the low word
  function automatic logic [StepBits-1:0] div_steps(input logic [NumBits-1:0]    rem_in,
                                                    input logic [WeightBits-1:0] low_in,
                                                    input logic [WeightBits-1:0] quo_in,
                                                    input logic [NumBits-1:0]    den);
    logic [NumBits:0]      trial;
    logic [NumBits-1:0]    rem;
    logic [WeightBits-1:0] low;
    logic [WeightBits-1:0] quo;
    rem = rem_in;
    low = low_in;
    quo = quo_in;
    for (int j = 0; j < StepsPerStage; j++) begin
      trial = {rem, low[WeightBits-1]};
      low   = low << 1;
      if (trial >= {1'b0, den}) begin
        trial = trial - {1'b0, den};
        quo   = {quo[WeightBits-2:0], 1'b1};
      end else begin
        quo   = {quo[WeightBits-2:0], 1'b0};
      end
      rem = trial[NumBits-1:0];
    end
    return {rem, low, quo};
  endfunction

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      for (int s = 1; s < NumStages; s++) begin
        if (en[s]) valid_q[s] <= valid_q[s-1];
      end
    end
  end

  // entry: scaled dividend, upper part as first remainder, overflow when quotient needs more than 32 bits
  always_comb begin
    side0_d = side_i;
    for (int l = 0; l < NumLanes; l++) begin
      dividend[l]    = {num_abs_i[l], {WEIGHT_FRAC_BITS{1'b0}}};
      rem0_d[l]      = NumBits'(dividend[l][DivBits-1:WeightBits]);
      low0_d[l]      = dividend[l][WeightBits-1:0];
      side0_d.ovf[l] = (rem0_d[l] >= den_abs_i);
    end
  end

  // quotient bits, a pair per stage
  always_comb begin
    for (int s = 0; s < NumSteps; s++) begin
      for (int l = 0; l < NumLanes; l++) begin
        step_d[s][l] = div_steps(rem_q[s][l], low_q[s][l], quo_q[s][l], den_q[s]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      den_q[0]  <= den_abs_i;
      side_q[0] <= side0_d;
      for (int l = 0; l < NumLanes; l++) begin
        rem_q[0][l] <= rem0_d[l];
        low_q[0][l] <= low0_d[l];
        quo_q[0][l] <= '0;
      end
    end
    for (int s = 1; s < NumStages; s++) begin
      if (en[s]) begin
        den_q[s]  <= den_q[s-1];
        side_q[s] <= side_q[s-1];
        for (int l = 0; l < NumLanes; l++) begin
          {rem_q[s][l], low_q[s][l], quo_q[s][l]} <= step_d[s-1][l];
        end
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[NumStages-1];
  assign quo_o       = quo_q[NumStages-1];
  assign side_o      = side_q[NumStages-1];

endmodule

>>> hdl/bc_out.sv
module bc_out
  import bc_pkg::*;
#(
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [WeightBits-1:0] quo_i [NumLanes],
  input  bc_side_t              side_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [WeightBits-1:0] weight_a_o,
  output logic [WeightBits-1:0] weight_b_o,
  output logic [WeightBits-1:0] weight_c_o,
  output logic                  degenerate_o,
  output logic                  saturated_o
);

  localparam int unsigned NumStages = 2;
  localparam int unsigned SumBits   = WeightBits + 2;
  localparam logic signed [SumBits-1:0] OneFix = SumBits'(1) <<< WEIGHT_FRAC_BITS;
  localparam logic signed [SumBits-1:0] SumMax = SumBits'($signed(WeightMaxBits));
  localparam logic signed [SumBits-1:0] SumMin = SumBits'($signed(WeightMinBits));

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  logic [WeightBits-1:0]     vw_d [NumLanes];
  logic [WeightBits-1:0]     vw_q [NumLanes];
  logic                      sat0_d, sat0_q;
  logic                      degen0_q;
  logic signed [SumBits-1:0] u_sum;
  logic [WeightBits-1:0]     u_d;
  logic                      sat1_d;
  logic [WeightBits-1:0]     wa_q, wb_q, wc_q;
  logic                      degen_q, sat_q;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    en[0]           = !valid_q[0] || en[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= in_valid_i;
      if (en[1]) valid_q[1] <= valid_q[0];
    end
  end

  // apply sign and clip v and w
  always_comb begin
    sat0_d = 1'b0;
    for (int l = 0; l < NumLanes; l++) begin
      if (side_i.neg[l]) begin
        if (side_i.ovf[l] || quo_i[l] > WeightMinBits) begin
          vw_d[l] = WeightMinBits;
          sat0_d  = 1'b1;
        end else begin
          vw_d[l] = WeightBits'(0) - quo_i[l];
        end
      end else begin
        if (side_i.ovf[l] || quo_i[l] > WeightMaxBits) begin
          vw_d[l] = WeightMaxBits;
          sat0_d  = 1'b1;
        end else begin
          vw_d[l] = quo_i[l];
        end
      end
    end
  end

  // u from the clipped v and w, then clip
  always_comb begin
    u_sum = OneFix - SumBits'($signed(vw_q[LaneV])) - SumBits'($signed(vw_q[LaneW]));
    if (u_sum > SumMax) begin
      u_d    = WeightMaxBits;
      sat1_d = 1'b1;
    end else if (u_sum < SumMin) begin
      u_d    = WeightMinBits;
      sat1_d = 1'b1;
    end else begin
      u_d    = u_sum[WeightBits-1:0];
      sat1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      vw_q     <= vw_d;
      sat0_q   <= sat0_d;
      degen0_q <= side_i.degen;
    end
    if (en[1]) begin
      degen_q <= degen0_q;
      if (degen0_q) begin
        wa_q  <= '0;
        wb_q  <= '0;
        wc_q  <= '0;
        sat_q <= 1'b0;
      end else begin
        wa_q  <= u_d;
        wb_q  <= vw_q[LaneV];
        wc_q  <= vw_q[LaneW];
        sat_q <= sat0_q || sat1_d;
      end
    end
  end

  assign in_ready_o   = en[0];
  assign out_valid_o  = valid_q[NumStages-1];
  assign weight_a_o   = wa_q;
  assign weight_b_o   = wb_q;
  assign weight_c_o   = wc_q;
  assign degenerate_o = degen_q;
  assign saturated_o  = sat_q;

endmodule

>>> hdl/barycentric_coordinates.sv
// channel  direction  handshake                 payload
// in       input      in_valid_i / in_ready_o   a_*_i, b_*_i, c_*_i, p_*_i (x, y, z)
// out      output     out_valid_o / out_ready_i weight_a_o, weight_b_o, weight_c_o,
//                                               degenerate_o, saturated_o
//
// one transfer per cycle in each direction unless a side stalls; the parts in order are edges and dot
// products, the split wide products and differences, the quotient pipeline (entry plus two
// restoring steps per stage for 32 quotient bits) and clipping.
// reset clears only the stage valid bits; no clearing pass.
// every stage holds while the next one is full and stalled, bubbles close up, so
// in_ready_o drops only when all stages hold data and out_ready_i is low.
module barycentric_coordinates
  import bc_pkg::*;
#(
  parameter int unsigned COORD_BITS       = 16,
  parameter int unsigned WEIGHT_FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] a_x_i,
  input  logic signed [COORD_BITS-1:0] a_y_i,
  input  logic signed [COORD_BITS-1:0] a_z_i,
  input  logic signed [COORD_BITS-1:0] b_x_i,
  input  logic signed [COORD_BITS-1:0] b_y_i,
  input  logic signed [COORD_BITS-1:0] b_z_i,
  input  logic signed [COORD_BITS-1:0] c_x_i,
  input  logic signed [COORD_BITS-1:0] c_y_i,
  input  logic signed [COORD_BITS-1:0] c_z_i,
  input  logic signed [COORD_BITS-1:0] p_x_i,
  input  logic signed [COORD_BITS-1:0] p_y_i,
  input  logic signed [COORD_BITS-1:0] p_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [WeightBits-1:0] weight_a_o,
  output logic signed [WeightBits-1:0] weight_b_o,
  output logic signed [WeightBits-1:0] weight_c_o,
  output logic                         degenerate_o,
  output logic                         saturated_o
);

  localparam int unsigned EdgeBits = COORD_BITS + 1;
  localparam int unsigned DotBits  = 2 * EdgeBits + 2;
  localparam int unsigned NumBits  = 2 * DotBits + 1;
  localparam logic [WeightBits-1:0] OneWeight = WeightBits'(1) << WEIGHT_FRAC_BITS;

  logic signed [COORD_BITS-1:0] pt [NumPoints][NumAxes];

  logic                      dot_valid, dot_ready;
  logic signed [DotBits-1:0] dot [NumDots];
  logic                      crs_valid, crs_ready;
  logic [NumBits-1:0]        num_abs [NumLanes];
  logic [NumBits-1:0]        den_abs;
  bc_side_t                  crs_side;
  logic                      div_valid, div_ready;
  logic [WeightBits-1:0]     quo [NumLanes];
  logic [WeightBits-1:0]     wa, wb, wc;
  bc_side_t                  div_side;

  // corner and point coordinates as one array
  assign pt[0][0] = a_x_i;
  assign pt[0][1] = a_y_i;
  assign pt[0][2] = a_z_i;
  assign pt[1][0] = b_x_i;
  assign pt[1][1] = b_y_i;
  assign pt[1][2] = b_z_i;
  assign pt[2][0] = c_x_i;
  assign pt[2][1] = c_y_i;
  assign pt[2][2] = c_z_i;
  assign pt[3][0] = p_x_i;
  assign pt[3][1] = p_y_i;
  assign pt[3][2] = p_z_i;

  // edge vectors and dot products
  bc_dot #(
    .COORD_BITS(COORD_BITS)
  ) u_dot (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pt_i       (pt),
    .out_valid_o(dot_valid),
    .out_ready_i(dot_ready),
    .dot_o      (dot)
  );

  // denominator and numerators
  bc_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dot_valid),
    .in_ready_o (dot_ready),
    .dot_i      (dot),
    .out_valid_o(crs_valid),
    .out_ready_i(crs_ready),
    .num_abs_o  (num_abs),
    .den_abs_o  (den_abs),
    .side_o     (crs_side)
  );

  // quotients of v and w
  bc_div #(
    .COORD_BITS      (COORD_BITS),
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (crs_valid),
    .in_ready_o (crs_ready),
    .num_abs_i  (num_abs),
    .den_abs_i  (den_abs),
    .side_i     (crs_side),
    .out_valid_o(div_valid),
    .out_ready_i(div_ready),
    .quo_o      (quo),
    .side_o     (div_side)
  );

  // sign, clipping, weight of a and output register
  bc_out #(
    .WEIGHT_FRAC_BITS(WEIGHT_FRAC_BITS)
  ) u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (div_ready),
    .quo_i       (quo),
    .side_i      (div_side),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .weight_a_o  (wa),
    .weight_b_o  (wb),
    .weight_c_o  (wc),
    .degenerate_o(degenerate_o),
    .saturated_o (saturated_o)
  );

  assign weight_a_o = $signed(wa);
  assign weight_b_o = $signed(wb);
  assign weight_c_o = $signed(wc);

  // degenerate triangle gives zero weights and no clip flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |->
      weight_a_o == '0 && weight_b_o == '0 && weight_c_o == '0 && !saturated_o)
    else $error("degenerate result with nonzero weights or clip flag");

  // unclipped weights sum to one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !degenerate_o && !saturated_o |->
      WeightBits'(wa + wb + wc) == OneWeight)
    else $error("weights do not sum to one");

  // input side only stalls when the whole pipeline is backed up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled while output side can move");

  // a stalled result stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(wa) && $stable(degenerate_o))
    else $error("stalled result changed");

endmodule
